// ===== rtl/ams_pkg.sv =====
// ----------------------------------------------------------------------------
// ams_pkg: shared types and codes of the accumulator machine
// Holds the function codes of the request channel, the opcode set and the
// structs that pass between the sequencer and the execute unit.
// ----------------------------------------------------------------------------
package ams_pkg;

   // Widths fixed by the request and result fields.
   localparam int unsigned PC_W   = 12;
   localparam int unsigned ACC_W  = 16;
   localparam int unsigned WORD_W = 17;
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned FUNC_W = 3;
   localparam int unsigned OP_W   = 5;

   // Request function codes; the remaining codes do nothing.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE     = 3'd0,
      FUNC_SET_PC    = 3'd1,
      FUNC_EXEC      = 3'd2,
      FUNC_IN_CHAR   = 3'd3,
      FUNC_OUT_TAKEN = 3'd4
   } func_type;

   // Instruction opcodes, bits 16..12 of an instruction word.
   typedef enum logic [OP_W-1:0] {
      OP_AND  = 5'd0,
      OP_ADD  = 5'd1,
      OP_LDA  = 5'd2,
      OP_STA  = 5'd3,
      OP_BUN  = 5'd4,
      OP_BSA  = 5'd5,
      OP_ISZ  = 5'd6,
      OP_OR   = 5'd7,
      OP_XOR  = 5'd8,
      OP_SUB  = 5'd9,
      OP_ILDA = 5'd10,
      OP_ISTA = 5'd11,
      OP_IBUN = 5'd12,
      OP_IADD = 5'd13,
      OP_CLA  = 5'd14,
      OP_CLE  = 5'd15,
      OP_CMA  = 5'd16,
      OP_CME  = 5'd17,
      OP_CIR  = 5'd18,
      OP_CIL  = 5'd19,
      OP_INC  = 5'd20,
      OP_SPA  = 5'd21,
      OP_SNA  = 5'd22,
      OP_SZA  = 5'd23,
      OP_SZE  = 5'd24,
      OP_HLT  = 5'd25,
      OP_INP  = 5'd26,
      OP_OUT  = 5'd27,
      OP_SKI  = 5'd28,
      OP_SKO  = 5'd29,
      OP_ION  = 5'd30,
      OP_IOF  = 5'd31
   } opcode_type;

   // Architectural registers seen by the execute unit.
   typedef struct packed {
      logic [ACC_W-1:0]  acc;
      logic              link;
      logic [PC_W-1:0]   pc;
      logic              ien;
      logic [CHAR_W-1:0] in_reg;
      logic              in_rdy;
      logic              out_rdy;
   } alu_ctx_type;

   // New register values and the store write of one instruction.
   typedef struct packed {
      logic [ACC_W-1:0] acc;
      logic             link;
      logic [PC_W-1:0]  pc;
      logic             ien;
      logic             halt;
      logic             in_rdy;
      logic             out_rdy;
      logic             out_emit;
      logic             mem_we;
      logic [ACC_W-1:0] mem_wdata;
   } alu_res_type;

endpackage

// ===== rtl/ams_store.sv =====
// ----------------------------------------------------------------------------
// ams_store: single-port word store
// One access per cycle, write or read, with the read data registered.
// ----------------------------------------------------------------------------
module ams_store #(
   parameter int unsigned DEPTH  = 4096,
   parameter int unsigned ADDR_W = 12,
   parameter int unsigned DATA_W = 17
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // Write port and registered read port share one address.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/ams_alu.sv =====
// ----------------------------------------------------------------------------
// ams_alu: instruction execute unit
// Works out the new registers, skip and store write of one decoded
// instruction from its opcode, operand and effective address.
// ----------------------------------------------------------------------------
module ams_alu (
   input  ams_pkg::opcode_type          op,
   input  logic [ams_pkg::ACC_W-1:0]    data,
   input  logic [ams_pkg::PC_W-1:0]     ea,
   input  ams_pkg::alu_ctx_type         ctx,
   output ams_pkg::alu_res_type         res
);

   import ams_pkg::*;

   logic [ACC_W:0]   sum;
   logic [ACC_W-1:0] data_inc;
   logic [PC_W-1:0]  pc_skip;

   assign sum      = {1'b0, ctx.acc} + {1'b0, data};
   assign data_inc = data + ACC_W'(1);
   assign pc_skip  = ctx.pc + PC_W'(1);

   // Opcode decode; register fields start from their old values, halt, out_emit and mem_we from zero.
   always_comb begin
      res.acc       = ctx.acc;
      res.link      = ctx.link;
      res.pc        = ctx.pc;
      res.ien       = ctx.ien;
      res.halt      = 1'b0;
      res.in_rdy    = ctx.in_rdy;
      res.out_rdy   = ctx.out_rdy;
      res.out_emit  = 1'b0;
      res.mem_we    = 1'b0;
      res.mem_wdata = ctx.acc;
      unique case (op)
         OP_AND:  res.acc = ctx.acc & data;
         OP_ADD, OP_IADD: begin
            res.acc  = sum[ACC_W-1:0];
            res.link = sum[ACC_W];
         end
         OP_LDA, OP_ILDA: res.acc = data;
         OP_STA, OP_ISTA: res.mem_we = 1'b1;
         OP_BUN, OP_IBUN: res.pc = ea;
         OP_BSA: begin
            res.mem_we    = 1'b1;
            res.mem_wdata = ACC_W'(ctx.pc);
            res.pc        = ea + PC_W'(1);
         end
         OP_ISZ: begin
            res.mem_we    = 1'b1;
            res.mem_wdata = data_inc;
            if (data_inc == '0) begin
               res.pc = pc_skip;
            end
         end
         OP_OR:   res.acc = ctx.acc | data;
         OP_XOR:  res.acc = ctx.acc ^ data;
         OP_SUB:  res.acc = ctx.acc - data;
         OP_CLA:  res.acc = '0;
         OP_CLE:  res.link = 1'b0;
         OP_CMA:  res.acc = ~ctx.acc;
         OP_CME:  res.link = ~ctx.link;
         // Rotates run over the 17 bits E:AC.
         OP_CIR: begin
            res.acc  = {ctx.link, ctx.acc[ACC_W-1:1]};
            res.link = ctx.acc[0];
         end
         OP_CIL: begin
            res.acc  = {ctx.acc[ACC_W-2:0], ctx.link};
            res.link = ctx.acc[ACC_W-1];
         end
         OP_INC:  res.acc = ctx.acc + ACC_W'(1);
         OP_SPA:  if (!ctx.acc[ACC_W-1]) res.pc = pc_skip;
         OP_SNA:  if (ctx.acc[ACC_W-1]) res.pc = pc_skip;
         OP_SZA:  if (ctx.acc == '0) res.pc = pc_skip;
         OP_SZE:  if (!ctx.link) res.pc = pc_skip;
         OP_HLT:  res.halt = 1'b1;
         OP_INP: begin
            res.acc    = ACC_W'(ctx.in_reg);
            res.in_rdy = 1'b0;
         end
         OP_OUT: begin
            res.out_emit = 1'b1;
            res.out_rdy  = 1'b0;
         end
         OP_SKI:  if (ctx.in_rdy) res.pc = pc_skip;
         OP_SKO:  if (ctx.out_rdy) res.pc = pc_skip;
         OP_ION:  res.ien = 1'b1;
         OP_IOF:  res.ien = 1'b0;
         default: res.ien = ctx.ien;
      endcase
   end

endmodule

// ===== rtl/accumulator_machine_step.sv =====
// ----------------------------------------------------------------------------
// accumulator_machine_step: accumulator machine, one request per beat
//
//   channel   ports                                   handshake
//   request   req_func req_addr req_word req_in_char  start, busy
//   response  rsp_pc_now ... rsp_out_flag             rsp_valid, one-cycle strobe
//
// After reset the store is cleared one word a cycle, with busy high. A store
// write, a PC load or a flag update answers in the next cycle.
// An execute runs through the states FETCH, PTR when indirect, and EXEC: the
// single store port does the fetch, the pointer read and the operand access
// in turn. An execute while halted answers in the next cycle. busy falls in
// the cycle the response beat is shown; the receiver cannot stall.
// ----------------------------------------------------------------------------
module accumulator_machine_step #(
   parameter int unsigned MEM_DEPTH = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ams_pkg::FUNC_W-1:0]     req_func,
   input  logic [ams_pkg::PC_W-1:0]       req_addr,
   input  logic [ams_pkg::WORD_W-1:0]     req_word,
   input  logic [ams_pkg::CHAR_W-1:0]     req_in_char,
   output logic                           rsp_valid,
   output logic [ams_pkg::PC_W-1:0]       rsp_pc_now,
   output logic [ams_pkg::ACC_W-1:0]      rsp_acc_now,
   output logic                           rsp_carry_bit,
   output logic                           rsp_halted,
   output logic [ams_pkg::CHAR_W-1:0]     rsp_out_char,
   output logic                           rsp_out_strobe,
   output logic                           rsp_irq_enable,
   output logic                           rsp_in_flag,
   output logic                           rsp_out_flag
);

   import ams_pkg::*;

   localparam int unsigned AW = $clog2(MEM_DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(MEM_DEPTH - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_PTR,
      S_EXEC
   } state_type;

   // Reduces a 12-bit address modulo the store depth by conditional subtracts.
   function automatic logic [AW-1:0] wrap_addr(input logic [PC_W-1:0] a);
      logic [19:0] v;
      v = {8'b0, a};
      for (int k = 7; k >= 0; k--) begin
         if (v >= (20'(MEM_DEPTH) << k)) begin
            v = v - (20'(MEM_DEPTH) << k);
         end
      end
      return v[AW-1:0];
   endfunction

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   opcode_type        op_ff, op_in;
   logic [PC_W-1:0]   ea_ff, ea_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              link_ff, link_in;
   logic              ien_ff, ien_in;
   logic              in_rdy_ff, in_rdy_in;
   logic              out_rdy_ff, out_rdy_in;
   logic [CHAR_W-1:0] in_reg_ff, in_reg_in;
   logic [CHAR_W-1:0] out_reg_ff, out_reg_in;
   logic              halt_ff, halt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_strobe_ff, out_strobe_in;

   logic              mem_we;
   logic [AW-1:0]     mem_addr;
   logic [WORD_W-1:0] mem_wdata;
   logic [WORD_W-1:0] mem_rdata;
   opcode_type        fetch_op;
   logic              fetch_ind;
   alu_ctx_type       alu_ctx;
   alu_res_type       alu_res;

   ams_store #(
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (AW),
      .DATA_W (WORD_W)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // Execute unit sees the registers as they stand in the operand cycle.
   assign alu_ctx.acc     = acc_ff;
   assign alu_ctx.link    = link_ff;
   assign alu_ctx.pc      = pc_ff;
   assign alu_ctx.ien     = ien_ff;
   assign alu_ctx.in_reg  = in_reg_ff;
   assign alu_ctx.in_rdy  = in_rdy_ff;
   assign alu_ctx.out_rdy = out_rdy_ff;

   ams_alu u_alu (
      .op   (op_ff),
      .data (mem_rdata[ACC_W-1:0]),
      .ea   (ea_ff),
      .ctx  (alu_ctx),
      .res  (alu_res)
   );

   // Indirect opcodes need a pointer read before the operand.
   assign fetch_op = opcode_type'(mem_rdata[WORD_W-1:PC_W]);
   always_comb begin
      case (fetch_op) inside
         OP_ILDA, OP_ISTA, OP_IBUN, OP_IADD: fetch_ind = 1'b1;
         default:                            fetch_ind = 1'b0;
      endcase
   end

   // Sequencer: store port control and next register values.
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      op_in         = op_ff;
      ea_in         = ea_ff;
      pc_in         = pc_ff;
      acc_in        = acc_ff;
      link_in       = link_ff;
      ien_in        = ien_ff;
      in_rdy_in     = in_rdy_ff;
      out_rdy_in    = out_rdy_ff;
      in_reg_in     = in_reg_ff;
      out_reg_in    = out_reg_ff;
      halt_in       = halt_ff;
      rsp_valid_in  = 1'b0;
      out_strobe_in = 1'b0;
      mem_we        = 1'b0;
      mem_addr      = wrap_addr(pc_ff);
      mem_wdata     = '0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_addr   = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               rsp_valid_in = 1'b1;
               case (func_type'(req_func))
                  FUNC_WRITE: begin
                     mem_we    = 1'b1;
                     mem_addr  = wrap_addr(req_addr);
                     mem_wdata = req_word;
                  end
                  FUNC_SET_PC: pc_in = req_addr;
                  FUNC_EXEC: begin
                     // Fetch starts now; the answer waits for the operand.
                     if (!halt_ff) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_FETCH;
                     end
                  end
                  FUNC_IN_CHAR: begin
                     in_reg_in = req_in_char;
                     in_rdy_in = 1'b1;
                  end
                  FUNC_OUT_TAKEN: out_rdy_in = 1'b1;
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_FETCH: begin
            op_in    = fetch_op;
            ea_in    = mem_rdata[PC_W-1:0];
            pc_in    = pc_ff + PC_W'(1);
            mem_addr = wrap_addr(mem_rdata[PC_W-1:0]);
            state_in = fetch_ind ? S_PTR : S_EXEC;
         end
         S_PTR: begin
            ea_in    = mem_rdata[PC_W-1:0];
            mem_addr = wrap_addr(mem_rdata[PC_W-1:0]);
            state_in = S_EXEC;
         end
         S_EXEC: begin
            acc_in        = alu_res.acc;
            link_in       = alu_res.link;
            pc_in         = alu_res.pc;
            ien_in        = alu_res.ien;
            halt_in       = halt_ff | alu_res.halt;
            in_rdy_in     = alu_res.in_rdy;
            out_rdy_in    = alu_res.out_rdy;
            out_strobe_in = alu_res.out_emit;
            if (alu_res.out_emit) begin
               out_reg_in = acc_ff[CHAR_W-1:0];
            end
            mem_we        = alu_res.mem_we;
            mem_addr      = wrap_addr(ea_ff);
            mem_wdata     = {1'b0, alu_res.mem_wdata};
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State, architectural registers and the registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         pc_ff         <= '0;
         acc_ff        <= '0;
         link_ff       <= 1'b0;
         ien_ff        <= 1'b0;
         in_rdy_ff     <= 1'b0;
         out_rdy_ff    <= 1'b0;
         in_reg_ff     <= '0;
         out_reg_ff    <= '0;
         halt_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         pc_ff         <= pc_in;
         acc_ff        <= acc_in;
         link_ff       <= link_in;
         ien_ff        <= ien_in;
         in_rdy_ff     <= in_rdy_in;
         out_rdy_ff    <= out_rdy_in;
         in_reg_ff     <= in_reg_in;
         out_reg_ff    <= out_reg_in;
         halt_ff       <= halt_in;
         rsp_valid_ff  <= rsp_valid_in;
         out_strobe_ff <= out_strobe_in;
      end
      op_ff <= op_in;
      ea_ff <= ea_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pc_now     = pc_ff;
   assign rsp_acc_now    = acc_ff;
   assign rsp_carry_bit  = link_ff;
   assign rsp_halted     = halt_ff;
   assign rsp_out_char   = out_reg_ff;
   assign rsp_out_strobe = out_strobe_ff;
   assign rsp_irq_enable = ien_ff;
   assign rsp_in_flag    = in_rdy_ff;
   assign rsp_out_flag   = out_rdy_ff;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the accumulator machine step block
// Drives scripted opening rows, then random store writes, PC loads, instruction
// executes and console flag beats, then scripted halt rows into the step block.
// A behavioral copy of the machine predicts each response beat unless a row
// gives its view; beats are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
   import ams_pkg::*;

   localparam int unsigned MEM_WORDS   = 4096;
   localparam int unsigned ITEM_COUNT  = 450;
   localparam int unsigned DRAIN_EVERY = 100;
   localparam int unsigned SETTLE      = 8;
   // Longest silent stretch is the store clear after reset; allow it several times.
   localparam int unsigned STALL_LIMIT = 20000;

   // Machine state as seen in one response beat.
   typedef struct packed {
      logic [PC_W-1:0]   pc_now;
      logic [ACC_W-1:0]  acc_now;
      logic              carry_bit;
      logic              halted;
      logic [CHAR_W-1:0] out_char;
      logic              out_strobe;
      logic              irq_enable;
      logic              in_flag;
      logic              out_flag;
   } machine_view_type;

   // One scripted request; a typed-in view replaces the prediction when given.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [PC_W-1:0]   addr;
      logic [WORD_W-1:0] word;
      logic [CHAR_W-1:0] char_in;
      logic              typed;
      machine_view_type  view;
   } stim_row_type;

   localparam machine_view_type V_RESET  = '0;
   localparam machine_view_type V_PC_TOP = '{pc_now: 12'hFFF, default: '0};
   localparam machine_view_type V_IN     = '{in_flag: 1'b1, default: '0};
   localparam machine_view_type V_IN_OUT = '{in_flag: 1'b1, out_flag: 1'b1, default: '0};

   localparam int unsigned HEAD_ROWS   = 23;
   localparam int unsigned SCRIPT_ROWS = 30;

   // Opening rows run before the random part, the halt rows after it.
   localparam stim_row_type SCRIPT [SCRIPT_ROWS] = '{
      // Reset state, store write and PC extremes, wrap of the PC on fetch, console flags, an unused code.
      '{FUNC_SET_PC,    12'h000, 17'h00000, 8'h00, 1'b1, V_RESET},
      '{FUNC_WRITE,     12'hFFF, 17'h1FFFF, 8'hFF, 1'b1, V_RESET},
      '{FUNC_SET_PC,    12'hFFF, 17'h00000, 8'h00, 1'b1, V_PC_TOP},
      '{FUNC_EXEC,      12'h000, 17'h00000, 8'h00, 1'b1, V_RESET},
      '{FUNC_IN_CHAR,   12'h000, 17'h00000, 8'hFF, 1'b1, V_IN},
      '{FUNC_OUT_TAKEN, 12'h000, 17'h00000, 8'h00, 1'b1, V_IN_OUT},
      '{3'd6,           12'hFFF, 17'h1FFFF, 8'hFF, 1'b1, V_IN_OUT},
      // A small program: enable, load all ones, add with carry out.
      '{FUNC_WRITE,     12'h000, {OP_ION, 12'h000},  8'h00, 1'b0, V_RESET},
      '{FUNC_EXEC,      12'h000, 17'h00000, 8'h00, 1'b0, V_RESET},
      '{FUNC_WRITE,     12'h001, {OP_LDA, 12'h800},  8'h00, 1'b0, V_RESET},
      '{FUNC_WRITE,     12'h800, 17'h1FFFF, 8'h00, 1'b0, V_RESET},
      '{FUNC_EXEC,      12'h000, 17'h00000, 8'h00, 1'b0, V_RESET},
      '{FUNC_WRITE,     12'h002, {OP_ADD, 12'h801},  8'h00, 1'b0, V_RESET},
      '{FUNC_WRITE,     12'h801, 17'h00001, 8'h00, 1'b0, V_RESET},
      '{FUNC_EXEC,      12'h000, 17'h00000, 8'h00, 1'b0, V_RESET},
      // Console in and out, then an indirect jump to the top of the store.
      '{FUNC_WRITE,     12'h003, {OP_INP, 12'h000},  8'h00, 1'b0, V_RESET},
      '{FUNC_EXEC,      12'h000, 17'h00000, 8'h00, 1'b0, V_RESET},
      '{FUNC_WRITE,     12'h004, {OP_OUT, 12'h000},  8'h00, 1'b0, V_RESET},
      '{FUNC_EXEC,      12'h000, 17'h00000, 8'h00, 1'b0, V_RESET},
      '{FUNC_WRITE,     12'h005, {OP_IBUN, 12'h800}, 8'h00, 1'b0, V_RESET},
      '{FUNC_EXEC,      12'h000, 17'h00000, 8'h00, 1'b0, V_RESET},
      '{FUNC_EXEC,      12'h000, 17'h00000, 8'h00, 1'b0, V_RESET},
      '{FUNC_SET_PC,    12'h000, 17'h00000, 8'h00, 1'b0, V_RESET},
      // Halt, then executes do nothing while the other functions still work.
      '{FUNC_WRITE,     12'h100, {OP_HLT, 12'hABC},  8'h00, 1'b0, V_RESET},
      '{FUNC_SET_PC,    12'h100, 17'h00000, 8'h00, 1'b0, V_RESET},
      '{FUNC_EXEC,      12'h000, 17'h00000, 8'h00, 1'b0, V_RESET},
      '{FUNC_WRITE,     12'h101, {OP_CLA, 12'h000},  8'h00, 1'b0, V_RESET},
      '{FUNC_EXEC,      12'h000, 17'h00000, 8'h00, 1'b0, V_RESET},
      '{FUNC_IN_CHAR,   12'h000, 17'h00000, 8'h00, 1'b0, V_RESET},
      '{3'd7,           12'h000, 17'h00000, 8'h00, 1'b0, V_RESET}
   };

   logic                clock;
   logic                reset       = 1'b1;
   logic                start       = 1'b0;
   logic [FUNC_W-1:0]   req_func    = '0;
   logic [PC_W-1:0]     req_addr    = '0;
   logic [WORD_W-1:0]   req_word    = '0;
   logic [CHAR_W-1:0]   req_in_char = '0;
   logic                busy;
   logic                rsp_valid;
   logic [PC_W-1:0]     rsp_pc_now;
   logic [ACC_W-1:0]    rsp_acc_now;
   logic                rsp_carry_bit;
   logic                rsp_halted;
   logic [CHAR_W-1:0]   rsp_out_char;
   logic                rsp_out_strobe;
   logic                rsp_irq_enable;
   logic                rsp_in_flag;
   logic                rsp_out_flag;

   // Behavioral copy of the machine state.
   logic [WORD_W-1:0]   mem_r [MEM_WORDS];
   logic [PC_W-1:0]     pc_r      = '0;
   logic [ACC_W-1:0]    acc_r     = '0;
   logic                link_r    = 1'b0;
   logic                ien_r     = 1'b0;
   logic                in_rdy_r  = 1'b0;
   logic                out_rdy_r = 1'b0;
   logic [CHAR_W-1:0]   in_reg_r  = '0;
   logic [CHAR_W-1:0]   out_reg_r = '0;
   logic                halt_r    = 1'b0;

   machine_view_type    expected_views [$];
   int unsigned         mismatch_count = 0;
   int unsigned         beats_sent     = 0;
   int unsigned         sweep_op       = 0;
   bit                  no_idle        = 1'b0;

   accumulator_machine_step #(
      .MEM_DEPTH(MEM_WORDS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_addr       (req_addr),
      .req_word       (req_word),
      .req_in_char    (req_in_char),
      .rsp_valid      (rsp_valid),
      .rsp_pc_now     (rsp_pc_now),
      .rsp_acc_now    (rsp_acc_now),
      .rsp_carry_bit  (rsp_carry_bit),
      .rsp_halted     (rsp_halted),
      .rsp_out_char   (rsp_out_char),
      .rsp_out_strobe (rsp_out_strobe),
      .rsp_irq_enable (rsp_irq_enable),
      .rsp_in_flag    (rsp_in_flag),
      .rsp_out_flag   (rsp_out_flag)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one request to the copy of the machine and returns the view after it.
   function automatic machine_view_type step_machine(input logic [FUNC_W-1:0] func,
                                                     input logic [PC_W-1:0] addr,
                                                     input logic [WORD_W-1:0] word,
                                                     input logic [CHAR_W-1:0] char_in);
      logic              strobe;
      logic [WORD_W-1:0] ir;
      opcode_type        op;
      logic [PC_W-1:0]   ea;
      logic [ACC_W-1:0]  operand;
      logic [ACC_W-1:0]  bumped;
      logic [ACC_W:0]    sum;
      strobe = 1'b0;
      case (func)
         FUNC_WRITE:     mem_r[addr] = word;
         FUNC_SET_PC:    pc_r = addr;
         FUNC_IN_CHAR: begin
            in_reg_r = char_in;
            in_rdy_r = 1'b1;
         end
         FUNC_OUT_TAKEN: out_rdy_r = 1'b1;
         FUNC_EXEC: if (!halt_r) begin
            ir = mem_r[pc_r];
            pc_r = pc_r + 12'd1;
            op = opcode_type'(ir[16:12]);
            ea = ir[11:0];
            // Indirect forms take the effective address from the pointer word.
            if (op >= OP_ILDA && op <= OP_IADD)
               ea = mem_r[ea][11:0];
            operand = mem_r[ea][15:0];
            case (op)
               OP_AND:          acc_r = acc_r & operand;
               OP_ADD, OP_IADD: begin
                  sum = {1'b0, acc_r} + {1'b0, operand};
                  link_r = sum[16];
                  acc_r = sum[15:0];
               end
               OP_LDA, OP_ILDA: acc_r = operand;
               OP_STA, OP_ISTA: mem_r[ea] = {1'b0, acc_r};
               OP_BUN, OP_IBUN: pc_r = ea;
               OP_BSA: begin
                  mem_r[ea] = {5'd0, pc_r};
                  pc_r = ea + 12'd1;
               end
               OP_ISZ: begin
                  bumped = operand + 16'd1;
                  mem_r[ea] = {1'b0, bumped};
                  if (bumped == 16'd0)
                     pc_r = pc_r + 12'd1;
               end
               OP_OR:  acc_r = acc_r | operand;
               OP_XOR: acc_r = acc_r ^ operand;
               OP_SUB: acc_r = acc_r - operand;
               OP_CLA: acc_r = '0;
               OP_CLE: link_r = 1'b0;
               OP_CMA: acc_r = ~acc_r;
               OP_CME: link_r = ~link_r;
               // Rotates move the 17 bits of link and accumulator together.
               OP_CIR: {acc_r, link_r} = {link_r, acc_r};
               OP_CIL: {link_r, acc_r} = {acc_r, link_r};
               OP_INC: acc_r = acc_r + 16'd1;
               OP_SPA: if (!acc_r[15]) pc_r = pc_r + 12'd1;
               OP_SNA: if (acc_r[15]) pc_r = pc_r + 12'd1;
               OP_SZA: if (acc_r == 16'd0) pc_r = pc_r + 12'd1;
               OP_SZE: if (!link_r) pc_r = pc_r + 12'd1;
               OP_HLT: halt_r = 1'b1;
               OP_INP: begin
                  acc_r = {8'd0, in_reg_r};
                  in_rdy_r = 1'b0;
               end
               OP_OUT: begin
                  out_reg_r = acc_r[7:0];
                  out_rdy_r = 1'b0;
                  strobe = 1'b1;
               end
               OP_SKI: if (in_rdy_r) pc_r = pc_r + 12'd1;
               OP_SKO: if (out_rdy_r) pc_r = pc_r + 12'd1;
               OP_ION: ien_r = 1'b1;
               OP_IOF: ien_r = 1'b0;
            endcase
         end
         default: ;
      endcase
      return '{pc_r, acc_r, link_r, halt_r, out_reg_r, strobe, ien_r, in_rdy_r, out_rdy_r};
   endfunction

   // Sends one request beat after a random gap and queues its expected view.
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [PC_W-1:0] addr,
                            input logic [WORD_W-1:0] word, input logic [CHAR_W-1:0] char_in,
                            input logic typed = 1'b0, input machine_view_type view = '0);
      int unsigned      gap;
      machine_view_type predicted;
      if ($urandom_range(0, 15) == 0)
         no_idle = !no_idle;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_func    <= func;
      req_addr    <= addr;
      req_word    <= word;
      req_in_char <= char_in;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = step_machine(func, addr, word, char_in);
      expected_views.push_back(typed ? view : predicted);
      beats_sent++;
   endtask

   // Holds the request side off until every response beat has come back.
   task automatic wait_drained();
      start <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
   endtask

   // Data words lean toward the sign, carry and zero boundaries.
   function automatic logic [WORD_W-1:0] pick_data();
      case ($urandom_range(0, 5))
         0:       return 17'h00000;
         1:       return 17'h1FFFF;
         2:       return {1'($urandom()), 16'h8000};
         3:       return {1'($urandom()), 16'h7FFF};
         default: return 17'($urandom());
      endcase
   endfunction

   // One instruction: operands and pointer set up, instruction placed at the PC, executed.
   task automatic run_one_instruction();
      opcode_type      op;
      logic [PC_W-1:0] ea;
      logic [PC_W-1:0] data_addr;
      if (sweep_op < 32) begin
         op = opcode_type'(5'(sweep_op));
         sweep_op++;
      end else begin
         op = opcode_type'(5'($urandom_range(0, 31)));
      end
      // A halt would end all execution, so it only runs at the very end.
      if (op == OP_HLT)
         op = OP_CME;
      ea = 12'($urandom());
      if ($urandom_range(0, 5) == 0)
         send_item(FUNC_SET_PC, 12'($urandom()), 17'($urandom()), 8'($urandom()));
      data_addr = ea;
      if (op >= OP_ILDA && op <= OP_IADD) begin
         data_addr = 12'($urandom());
         send_item(FUNC_WRITE, ea, {5'($urandom()), data_addr}, 8'($urandom()));
      end
      if (op <= OP_IADD || $urandom_range(0, 3) == 0)
         send_item(FUNC_WRITE, data_addr, pick_data(), 8'($urandom()));
      if ((op == OP_INP || op == OP_SKI) && $urandom_range(0, 1) == 0)
         send_item(FUNC_IN_CHAR, 12'($urandom()), 17'($urandom()), 8'($urandom()));
      if ((op == OP_OUT || op == OP_SKO) && $urandom_range(0, 1) == 0)
         send_item(FUNC_OUT_TAKEN, 12'($urandom()), 17'($urandom()), 8'($urandom()));
      send_item(FUNC_WRITE, pc_r, {op, ea}, 8'($urandom()));
      send_item(FUNC_EXEC, 12'($urandom()), 17'($urandom()), 8'($urandom()));
   endtask

   // Any single beat with all fields random; an execute that would halt is redirected.
   task automatic send_noise();
      logic [FUNC_W-1:0] func;
      func = 3'($urandom());
      if (func == FUNC_EXEC && mem_r[pc_r][16:12] == OP_HLT)
         func = FUNC_SET_PC;
      send_item(func, 12'($urandom()), 17'($urandom()), 8'($urandom()));
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Response checker: each beat is matched against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      machine_view_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_views.size() == 0) begin
            $error("response beat with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_views.pop_front();
            check_field("pc_now", want.pc_now, rsp_pc_now);
            check_field("acc_now", want.acc_now, rsp_acc_now);
            check_field("carry_bit", want.carry_bit, rsp_carry_bit);
            check_field("halted", want.halted, rsp_halted);
            check_field("out_char", want.out_char, rsp_out_char);
            check_field("out_strobe", want.out_strobe, rsp_out_strobe);
            check_field("irq_enable", want.irq_enable, rsp_irq_enable);
            check_field("in_flag", want.in_flag, rsp_in_flag);
            check_field("out_flag", want.out_flag, rsp_out_flag);
         end
      end
   end

   // Watchdog: ends the run after too many cycles with no beat on either side.
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid === 1'b1)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   // Main sequence: reset, opening rows, random programs, halt rows.
   initial begin : stimulus
      int unsigned next_drain;
      foreach (mem_r[i])
         mem_r[i] = '0;
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < HEAD_ROWS; i++)
         send_item(SCRIPT[i].func, SCRIPT[i].addr, SCRIPT[i].word, SCRIPT[i].char_in,
                   SCRIPT[i].typed, SCRIPT[i].view);
      wait_drained();

      next_drain = beats_sent + DRAIN_EVERY;
      while (beats_sent < ITEM_COUNT - (SCRIPT_ROWS - HEAD_ROWS)) begin
         if (beats_sent >= next_drain) begin
            wait_drained();
            next_drain = beats_sent + DRAIN_EVERY;
         end
         if ($urandom_range(0, 4) == 0)
            send_noise();
         else
            run_one_instruction();
      end

      for (int i = HEAD_ROWS; i < SCRIPT_ROWS; i++)
         send_item(SCRIPT[i].func, SCRIPT[i].addr, SCRIPT[i].word, SCRIPT[i].char_in,
                   SCRIPT[i].typed, SCRIPT[i].view);

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ams_pkg.sv
rtl/ams_store.sv
rtl/ams_alu.sv
rtl/accumulator_machine_step.sv
dv/tb_top.sv
